[rtl/hbd_pkg.sv]
// hbd_pkg: shared types and constants for the H-bridge drive sequencer.
// Command, heading and register codes, config and result structs.
// No dependencies.
`default_nettype none

package hbd_pkg;

  localparam int DUTY_W  = 7;
  localparam int TICK_W  = 16;
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 9;
  localparam int HEAD_W  = 3;
  localparam int PINS_W  = 4;
  localparam int REG_IDX_W = 3;
  localparam int REG_DATA_W = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BWD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FWD    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SPEED  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_IGNORE = 3'd7;

  // heading codes
  localparam logic [HEAD_W-1:0] HEAD_STOP  = 3'd0;
  localparam logic [HEAD_W-1:0] HEAD_BWD   = 3'd1;
  localparam logic [HEAD_W-1:0] HEAD_FWD   = 3'd2;
  localparam logic [HEAD_W-1:0] HEAD_LEFT  = 3'd3;
  localparam logic [HEAD_W-1:0] HEAD_RIGHT = 3'd4;

  // pin patterns {left_fwd, left_rev, right_fwd, right_rev}
  localparam logic [PINS_W-1:0] PINS_OFF   = 4'h0;
  localparam logic [PINS_W-1:0] PINS_BWD   = 4'h5;
  localparam logic [PINS_W-1:0] PINS_FWD   = 4'hA;
  localparam logic [PINS_W-1:0] PINS_LEFT  = 4'h2;
  localparam logic [PINS_W-1:0] PINS_RIGHT = 4'h8;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_LOWEST_DUTY  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGHEST_DUTY = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TURN_DUTY    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_DUTY = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE_TICKS = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_TICKS   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SHORT_TICKS  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LONG_TICKS   = 3'd7;

  // register reset values
  localparam logic [DUTY_W-1:0] LOWEST_DUTY_RST  = 7'd20;
  localparam logic [DUTY_W-1:0] HIGHEST_DUTY_RST = 7'd100;
  localparam logic [DUTY_W-1:0] TURN_DUTY_RST    = 7'd50;
  localparam logic [DUTY_W-1:0] DEFAULT_DUTY_RST = 7'd50;
  localparam logic [TICK_W-1:0] SETTLE_TICKS_RST = 16'd120;
  localparam logic [TICK_W-1:0] RAMP_TICKS_RST   = 16'd30;
  localparam logic [TICK_W-1:0] SHORT_TICKS_RST  = 16'd250;
  localparam logic [TICK_W-1:0] LONG_TICKS_RST   = 16'd600;

  // turns of this many degrees or more use the long time
  localparam logic [VALUE_W-1:0] LONG_TURN_DEG = 9'd89;

  typedef struct packed {
    logic [DUTY_W-1:0] lowest_duty;
    logic [DUTY_W-1:0] highest_duty;
    logic [DUTY_W-1:0] turn_duty;
    logic [DUTY_W-1:0] default_duty;
    logic [TICK_W-1:0] stop_settle_ticks;
    logic [TICK_W-1:0] ramp_step_ticks;
    logic [TICK_W-1:0] short_turn_ticks;
    logic [TICK_W-1:0] long_turn_ticks;
  } cfg_t;

  typedef struct packed {
    logic              left_fwd_pin;
    logic              left_rev_pin;
    logic              right_fwd_pin;
    logic              right_rev_pin;
    logic [DUTY_W-1:0] duty_out;
    logic [HEAD_W-1:0] heading;
    logic              busy_res;
    logic              accepted;
  } res_t;

endpackage

`default_nettype wire

[rtl/hbd_intf.sv]
// hbd_intf: valid/ready channel interfaces for commands, results and config writes.
// Depends on hbd_pkg for field widths.
`default_nettype none

interface hbd_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [hbd_pkg::CMD_W-1:0]    cmd;
  logic [hbd_pkg::VALUE_W-1:0]  value;
  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface hbd_res_if;
  logic                         valid;
  logic                         ready;
  logic                         left_fwd_pin;
  logic                         left_rev_pin;
  logic                         right_fwd_pin;
  logic                         right_rev_pin;
  logic [hbd_pkg::DUTY_W-1:0]   duty_out;
  logic [hbd_pkg::HEAD_W-1:0]   heading;
  logic                         busy_res;
  logic                         accepted;
  modport source (output valid, left_fwd_pin, left_rev_pin, right_fwd_pin, right_rev_pin,
                  duty_out, heading, busy_res, accepted, input ready);
  modport sink   (input valid, left_fwd_pin, left_rev_pin, right_fwd_pin, right_rev_pin,
                  duty_out, heading, busy_res, accepted, output ready);
endinterface

interface hbd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hbd_pkg::REG_IDX_W-1:0]  index;
  logic [hbd_pkg::REG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/h_bridge_drive_sequencer.sv]
// h_bridge_drive_sequencer: top level; input register, sequencer core, result register.
// Depends on hbd_pkg, hbd_intf, hbd_cfg_regs and hbd_seq_core.
//
//  channel  | dir | payload                                   | transfer when
//  ---------+-----+-------------------------------------------+----------------------
//  cmd_ch   | in  | cmd, value                                | valid && ready
//  res_ch   | out | four pins, duty_out, heading, busy, acc.  | valid && ready
//  cfg      | in  | index, data                               | valid && ready (ready=1)
//
// Two-stage pipeline: an item sits in the input register, its state update
// and result are computed by the core and land in the result register. One item per
// cycle sustained while res_ch is ready. A stalled result holds both stages; the input
// side still takes a transfer while its register is empty or the result register is
// free or draining.
// rst (synchronous) clears the sequencer state and loads register defaults.
`default_nettype none

module h_bridge_drive_sequencer (
  input  wire logic clk,
  input  wire logic rst,
  hbd_cmd_if.sink   cmd_ch,
  hbd_res_if.source res_ch,
  hbd_cfg_if.sink   cfg
);

  hbd_pkg::cfg_t regs;
  hbd_pkg::res_t res;
  hbd_pkg::res_t res_q;

  logic                        in_valid;
  logic [hbd_pkg::CMD_W-1:0]   in_cmd;
  logic [hbd_pkg::VALUE_W-1:0] in_value;
  logic                        out_valid;
  logic                        out_free;
  logic                        fire;

  assign out_free     = !out_valid || res_ch.ready;
  assign fire         = in_valid && out_free;
  assign cmd_ch.ready = !in_valid || out_free;

  hbd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  hbd_seq_core u_core (
    .clk   (clk),
    .rst   (rst),
    .regs  (regs),
    .fire  (fire),
    .cmd   (in_cmd),
    .value (in_value),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd_ch.ready) begin
      in_valid <= cmd_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ch.ready && cmd_ch.valid) begin
      in_cmd   <= cmd_ch.cmd;
      in_value <= cmd_ch.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign res_ch.valid         = out_valid;
  assign res_ch.left_fwd_pin  = res_q.left_fwd_pin;
  assign res_ch.left_rev_pin  = res_q.left_rev_pin;
  assign res_ch.right_fwd_pin = res_q.right_fwd_pin;
  assign res_ch.right_rev_pin = res_q.right_rev_pin;
  assign res_ch.duty_out      = res_q.duty_out;
  assign res_ch.heading       = res_q.heading;
  assign res_ch.busy_res      = res_q.busy_res;
  assign res_ch.accepted      = res_q.accepted;

endmodule

`default_nettype wire

[rtl/hbd_cfg_regs.sv]
// hbd_cfg_regs: configuration register file, written over the config channel.
// Depends on hbd_pkg and hbd_cfg_if.
`default_nettype none

module hbd_cfg_regs (
  input  wire logic   clk,
  input  wire logic   rst,
  hbd_cfg_if.sink     cfg,
  output hbd_pkg::cfg_t regs
);

  hbd_pkg::cfg_t regs_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      unique case (cfg.index)
        hbd_pkg::REG_LOWEST_DUTY:  regs_next.lowest_duty       = cfg.data[hbd_pkg::DUTY_W-1:0];
        hbd_pkg::REG_HIGHEST_DUTY: regs_next.highest_duty      = cfg.data[hbd_pkg::DUTY_W-1:0];
        hbd_pkg::REG_TURN_DUTY:    regs_next.turn_duty         = cfg.data[hbd_pkg::DUTY_W-1:0];
        hbd_pkg::REG_DEFAULT_DUTY: regs_next.default_duty      = cfg.data[hbd_pkg::DUTY_W-1:0];
        hbd_pkg::REG_SETTLE_TICKS: regs_next.stop_settle_ticks = cfg.data;
        hbd_pkg::REG_RAMP_TICKS:   regs_next.ramp_step_ticks   = cfg.data;
        hbd_pkg::REG_SHORT_TICKS:  regs_next.short_turn_ticks  = cfg.data;
        hbd_pkg::REG_LONG_TICKS:   regs_next.long_turn_ticks   = cfg.data;
        default:                   regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.lowest_duty       <= hbd_pkg::LOWEST_DUTY_RST;
      regs.highest_duty      <= hbd_pkg::HIGHEST_DUTY_RST;
      regs.turn_duty         <= hbd_pkg::TURN_DUTY_RST;
      regs.default_duty      <= hbd_pkg::DEFAULT_DUTY_RST;
      regs.stop_settle_ticks <= hbd_pkg::SETTLE_TICKS_RST;
      regs.ramp_step_ticks   <= hbd_pkg::RAMP_TICKS_RST;
      regs.short_turn_ticks  <= hbd_pkg::SHORT_TICKS_RST;
      regs.long_turn_ticks   <= hbd_pkg::LONG_TICKS_RST;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

`default_nettype wire

[rtl/hbd_seq_core.sv]
// hbd_seq_core: sequencer state and the per-item next-state / result logic.
// Depends on hbd_pkg. Item comes from the input register, result goes to the output register.
`default_nettype none

module hbd_seq_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire hbd_pkg::cfg_t               regs,
  input  wire logic                        fire,
  input  wire logic [hbd_pkg::CMD_W-1:0]   cmd,
  input  wire logic [hbd_pkg::VALUE_W-1:0] value,
  output hbd_pkg::res_t                    res
);

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_STOP     = 7'b0000010,
    PH_PREDRIVE = 7'b0000100,
    PH_RAMP     = 7'b0001000,
    PH_PRETURN  = 7'b0010000,
    PH_TURN     = 7'b0100000,
    PH_POSTTURN = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [hbd_pkg::HEAD_W-1:0] heading_reg;
    phase_t                     phase;
    logic [hbd_pkg::TICK_W-1:0] tick_count;
    logic [hbd_pkg::DUTY_W-1:0] duty_reg;
    logic [hbd_pkg::DUTY_W-1:0] target_duty;
    logic [hbd_pkg::DUTY_W-1:0] saved_duty;
    logic [hbd_pkg::PINS_W-1:0] pin_levels;
    logic [hbd_pkg::PINS_W-1:0] pending_pins;
  } seq_t;

  seq_t seq, seq_next;
  seq_t pre;
  logic acc;

  // floor first, then ceiling: ceiling wins when the limits cross
  function automatic logic [hbd_pkg::DUTY_W-1:0] clamp_duty(
      input logic [hbd_pkg::VALUE_W-1:0] v, input hbd_pkg::cfg_t c);
    logic [hbd_pkg::VALUE_W-1:0] t;
    t = v;
    if (t < {2'b00, c.lowest_duty})  t = {2'b00, c.lowest_duty};
    if (t > {2'b00, c.highest_duty}) t = {2'b00, c.highest_duty};
    return t[hbd_pkg::DUTY_W-1:0];
  endfunction

  function automatic logic [hbd_pkg::HEAD_W-1:0] heading_of(
      input logic [hbd_pkg::PINS_W-1:0] pins);
    logic [hbd_pkg::HEAD_W-1:0] h;
    case (pins)
      hbd_pkg::PINS_BWD:   h = hbd_pkg::HEAD_BWD;
      hbd_pkg::PINS_FWD:   h = hbd_pkg::HEAD_FWD;
      hbd_pkg::PINS_LEFT:  h = hbd_pkg::HEAD_LEFT;
      hbd_pkg::PINS_RIGHT: h = hbd_pkg::HEAD_RIGHT;
      default:             h = hbd_pkg::HEAD_STOP;
    endcase
    return h;
  endfunction

  // One phase transition. A zero-length ramp step finishes the whole ramp at once,
  // so three of these in a row cover the longest chain of expired waits.
  function automatic seq_t step(input seq_t s, input hbd_pkg::cfg_t c);
    seq_t n;
    logic [hbd_pkg::TICK_W-1:0] lim;
    n = s;
    unique case (s.phase)
      PH_RAMP: lim = c.ramp_step_ticks;
      PH_TURN: lim = s.target_duty[0] ? c.long_turn_ticks : c.short_turn_ticks;
      default: lim = c.stop_settle_ticks;
    endcase
    if (s.phase != PH_IDLE && s.tick_count >= lim) begin
      n.tick_count = '0;
      unique case (s.phase)
        PH_PREDRIVE: begin
          n.pin_levels = s.pending_pins;
          if (s.target_duty >= c.lowest_duty) begin
            n.saved_duty = c.lowest_duty;
            n.duty_reg   = clamp_duty({2'b00, c.lowest_duty}, c);
            n.phase      = PH_RAMP;
          end else begin
            n.heading_reg = heading_of(s.pending_pins);
            n.phase       = PH_IDLE;
          end
        end
        PH_RAMP: begin
          if (s.saved_duty >= s.target_duty) begin
            n.heading_reg = heading_of(s.pending_pins);
            n.phase       = PH_IDLE;
          end else if (lim == '0) begin
            n.saved_duty  = s.target_duty;
            n.duty_reg    = clamp_duty({2'b00, s.target_duty}, c);
            n.heading_reg = heading_of(s.pending_pins);
            n.phase       = PH_IDLE;
          end else begin
            n.saved_duty = s.saved_duty + 7'd1;
            n.duty_reg   = clamp_duty({2'b00, s.saved_duty + 7'd1}, c);
          end
        end
        PH_PRETURN: begin
          n.duty_reg   = clamp_duty({2'b00, c.turn_duty}, c);
          n.pin_levels = s.pending_pins;
          n.phase      = PH_TURN;
        end
        PH_TURN: begin
          n.pin_levels = hbd_pkg::PINS_OFF;
          n.phase      = PH_POSTTURN;
        end
        PH_POSTTURN: begin
          n.duty_reg    = clamp_duty({2'b00, s.saved_duty}, c);
          n.heading_reg = heading_of(s.pending_pins);
          n.phase       = PH_IDLE;
        end
        default: n.phase = PH_IDLE;
      endcase
    end
    return n;
  endfunction

  function automatic seq_t start(input seq_t s, input phase_t ph);
    seq_t n;
    n = s;
    n.pin_levels  = hbd_pkg::PINS_OFF;
    n.heading_reg = hbd_pkg::HEAD_STOP;
    n.phase       = ph;
    n.tick_count  = '0;
    return n;
  endfunction

  always_comb begin
    pre = seq;
    acc = 1'b0;
    if (cmd == hbd_pkg::CMD_TICK) begin
      if (seq.phase != PH_IDLE) pre.tick_count = seq.tick_count + 16'd1;
    end else if (cmd != hbd_pkg::CMD_IGNORE && seq.phase == PH_IDLE) begin
      acc = 1'b1;
      case (cmd)
        hbd_pkg::CMD_STOP: pre = start(seq, PH_STOP);
        hbd_pkg::CMD_BWD, hbd_pkg::CMD_FWD: begin
          // repeating the current direction is taken but changes nothing
          if (seq.heading_reg != cmd) begin
            pre = seq;
            pre.pending_pins = (cmd == hbd_pkg::CMD_FWD) ? hbd_pkg::PINS_FWD : hbd_pkg::PINS_BWD;
            pre.target_duty  = seq.duty_reg;
            pre = start(pre, PH_PREDRIVE);
          end
        end
        hbd_pkg::CMD_LEFT, hbd_pkg::CMD_RIGHT: begin
          pre = seq;
          pre.pending_pins = (cmd == hbd_pkg::CMD_LEFT) ? hbd_pkg::PINS_LEFT
                                                         : hbd_pkg::PINS_RIGHT;
          pre.saved_duty   = seq.duty_reg;
          pre.target_duty  = (value < hbd_pkg::LONG_TURN_DEG) ? 7'd0 : 7'd1;
          pre = start(pre, PH_PRETURN);
        end
        default: pre.duty_reg = clamp_duty(value, regs);
      endcase
    end
    // waits shortened by a register write resolve only on a tick or a taken command
    if (cmd == hbd_pkg::CMD_TICK || acc) begin
      seq_next = step(step(step(pre, regs), regs), regs);
    end else begin
      seq_next = pre;
    end
  end

  always_comb begin
    res.left_fwd_pin  = seq_next.pin_levels[3];
    res.left_rev_pin  = seq_next.pin_levels[2];
    res.right_fwd_pin = seq_next.pin_levels[1];
    res.right_rev_pin = seq_next.pin_levels[0];
    res.duty_out      = seq_next.duty_reg;
    res.heading       = seq_next.heading_reg;
    res.busy_res      = (seq_next.phase != PH_IDLE);
    res.accepted      = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq.heading_reg  <= hbd_pkg::HEAD_STOP;
      seq.phase        <= PH_IDLE;
      seq.tick_count   <= '0;
      seq.duty_reg     <= hbd_pkg::DEFAULT_DUTY_RST;
      seq.target_duty  <= '0;
      seq.saved_duty   <= '0;
      seq.pin_levels   <= hbd_pkg::PINS_OFF;
      seq.pending_pins <= hbd_pkg::PINS_OFF;
    end else if (fire) begin
      seq <= seq_next;
    end
  end

endmodule

`default_nettype wire

[dv/h_bridge_drive_sequencer_tb.sv]
// h_bridge_drive_sequencer_tb: self-checking bench for the H-bridge drive sequencer.
// Needs hbd_pkg, the channel interfaces in hbd_intf and the RTL top level. Commands,
// ticks and register writes go in; each status transfer is checked against a model.
module h_bridge_drive_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_STOP, SEQ_PREDRIVE, SEQ_RAMP, SEQ_PRETURN, SEQ_TURN, SEQ_POSTTURN
  } seq_phase_t;

  logic clk;
  logic rst;

  hbd_cmd_if cmd_ch ();
  hbd_res_if res_ch ();
  hbd_cfg_if cfg_ch ();

  h_bridge_drive_sequencer dut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch),
    .cfg    (cfg_ch)
  );

  // model of the sequencer
  logic [15:0] regs [0:7];
  seq_phase_t  m_phase;
  logic [2:0]  m_head;
  logic [15:0] m_ticks;
  logic [6:0]  m_duty;
  logic [6:0]  m_goal;
  logic [6:0]  m_step;
  logic [3:0]  m_pins;
  logic [3:0]  m_pend;

  hbd_pkg::res_t pending_status [$];

  int mismatches;
  int items_sent;
  int status_checked;
  int settings_loaded;
  int send_gap_pct;
  int recv_gap_pct;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, wanted %0d", name, got, want));
  endtask

  function automatic logic [6:0] clamp_duty(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (r < regs[hbd_pkg::REG_LOWEST_DUTY][8:0]) r = regs[hbd_pkg::REG_LOWEST_DUTY][8:0];
    if (r > regs[hbd_pkg::REG_HIGHEST_DUTY][8:0]) r = regs[hbd_pkg::REG_HIGHEST_DUTY][8:0];
    return r[6:0];
  endfunction

  function automatic logic [2:0] heading_for(input logic [3:0] pins);
    case (pins)
      hbd_pkg::PINS_BWD:   return hbd_pkg::HEAD_BWD;
      hbd_pkg::PINS_FWD:   return hbd_pkg::HEAD_FWD;
      hbd_pkg::PINS_LEFT:  return hbd_pkg::HEAD_LEFT;
      hbd_pkg::PINS_RIGHT: return hbd_pkg::HEAD_RIGHT;
      default:             return hbd_pkg::HEAD_STOP;
    endcase
  endfunction

  function automatic logic [15:0] wait_ticks();
    case (m_phase)
      SEQ_RAMP: return regs[hbd_pkg::REG_RAMP_TICKS];
      SEQ_TURN: return m_goal[0] ? regs[hbd_pkg::REG_LONG_TICKS]
                                 : regs[hbd_pkg::REG_SHORT_TICKS];
      default:  return regs[hbd_pkg::REG_SETTLE_TICKS];
    endcase
  endfunction

  // zero or shortened waits chain through several phases at once
  task automatic settle_waits();
    while (m_phase != SEQ_IDLE && m_ticks >= wait_ticks()) begin
      m_ticks = '0;
      case (m_phase)
        SEQ_PREDRIVE: begin
          m_pins = m_pend;
          if (m_goal >= regs[hbd_pkg::REG_LOWEST_DUTY][6:0]) begin
            m_step  = regs[hbd_pkg::REG_LOWEST_DUTY][6:0];
            m_duty  = clamp_duty({2'b00, m_step});
            m_phase = SEQ_RAMP;
          end else begin
            m_head  = heading_for(m_pend);
            m_phase = SEQ_IDLE;
          end
        end
        SEQ_RAMP: begin
          if (m_step >= m_goal) begin
            m_head  = heading_for(m_pend);
            m_phase = SEQ_IDLE;
          end else begin
            m_step = m_step + 7'd1;
            m_duty = clamp_duty({2'b00, m_step});
          end
        end
        SEQ_PRETURN: begin
          m_duty  = clamp_duty(regs[hbd_pkg::REG_TURN_DUTY][8:0]);
          m_pins  = m_pend;
          m_phase = SEQ_TURN;
        end
        SEQ_TURN: begin
          m_pins  = hbd_pkg::PINS_OFF;
          m_phase = SEQ_POSTTURN;
        end
        SEQ_POSTTURN: begin
          m_duty  = clamp_duty({2'b00, m_step});
          m_head  = heading_for(m_pend);
          m_phase = SEQ_IDLE;
        end
        default: m_phase = SEQ_IDLE;
      endcase
    end
  endtask

  task automatic enter_phase(input seq_phase_t ph);
    m_pins  = hbd_pkg::PINS_OFF;
    m_head  = hbd_pkg::HEAD_STOP;
    m_phase = ph;
    m_ticks = '0;
    settle_waits();
  endtask

  task automatic reset_sequencer_model();
    regs[hbd_pkg::REG_LOWEST_DUTY]  = 16'(hbd_pkg::LOWEST_DUTY_RST);
    regs[hbd_pkg::REG_HIGHEST_DUTY] = 16'(hbd_pkg::HIGHEST_DUTY_RST);
    regs[hbd_pkg::REG_TURN_DUTY]    = 16'(hbd_pkg::TURN_DUTY_RST);
    regs[hbd_pkg::REG_DEFAULT_DUTY] = 16'(hbd_pkg::DEFAULT_DUTY_RST);
    regs[hbd_pkg::REG_SETTLE_TICKS] = hbd_pkg::SETTLE_TICKS_RST;
    regs[hbd_pkg::REG_RAMP_TICKS]   = hbd_pkg::RAMP_TICKS_RST;
    regs[hbd_pkg::REG_SHORT_TICKS]  = hbd_pkg::SHORT_TICKS_RST;
    regs[hbd_pkg::REG_LONG_TICKS]   = hbd_pkg::LONG_TICKS_RST;
    m_phase = SEQ_IDLE;
    m_head  = hbd_pkg::HEAD_STOP;
    m_ticks = '0;
    m_duty  = hbd_pkg::DEFAULT_DUTY_RST;
    m_goal  = '0;
    m_step  = '0;
    m_pins  = hbd_pkg::PINS_OFF;
    m_pend  = hbd_pkg::PINS_OFF;
  endtask

  // During a drive m_goal is the ramp goal and m_step the ramp step; during a turn
  // m_step holds the duty to restore and m_goal[0] picks the long turn time.
  task automatic step_sequencer(input logic [2:0] c, input logic [8:0] v,
                                output hbd_pkg::res_t r);
    logic took;
    took = 1'b0;
    if (c == hbd_pkg::CMD_TICK) begin
      if (m_phase != SEQ_IDLE) begin
        m_ticks = m_ticks + 16'd1;
        settle_waits();
      end
    end else if (c != hbd_pkg::CMD_IGNORE && m_phase == SEQ_IDLE) begin
      took = 1'b1;
      case (c)
        hbd_pkg::CMD_STOP: enter_phase(SEQ_STOP);
        hbd_pkg::CMD_BWD, hbd_pkg::CMD_FWD: begin
          // same direction again is taken but changes nothing
          if (m_head != ((c == hbd_pkg::CMD_FWD) ? hbd_pkg::HEAD_FWD : hbd_pkg::HEAD_BWD)) begin
            m_pend = (c == hbd_pkg::CMD_FWD) ? hbd_pkg::PINS_FWD : hbd_pkg::PINS_BWD;
            m_goal = m_duty;
            enter_phase(SEQ_PREDRIVE);
          end
        end
        hbd_pkg::CMD_LEFT, hbd_pkg::CMD_RIGHT: begin
          m_pend = (c == hbd_pkg::CMD_LEFT) ? hbd_pkg::PINS_LEFT : hbd_pkg::PINS_RIGHT;
          m_step = m_duty;
          m_goal = (v < hbd_pkg::LONG_TURN_DEG) ? 7'd0 : 7'd1;
          enter_phase(SEQ_PRETURN);
        end
        default: m_duty = clamp_duty(v);
      endcase
    end
    r.left_fwd_pin  = m_pins[3];
    r.left_rev_pin  = m_pins[2];
    r.right_fwd_pin = m_pins[1];
    r.right_rev_pin = m_pins[0];
    r.duty_out      = m_duty;
    r.heading       = m_head;
    r.busy_res      = (m_phase != SEQ_IDLE);
    r.accepted      = took;
  endtask

  // status side: ready at the falling edge, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin : status_check
    hbd_pkg::res_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("status transfer with nothing pending");
      end else begin
        want = pending_status.pop_front();
        check_field("left_fwd_pin", 8'(res_ch.left_fwd_pin), 8'(want.left_fwd_pin));
        check_field("left_rev_pin", 8'(res_ch.left_rev_pin), 8'(want.left_rev_pin));
        check_field("right_fwd_pin", 8'(res_ch.right_fwd_pin), 8'(want.right_fwd_pin));
        check_field("right_rev_pin", 8'(res_ch.right_rev_pin), 8'(want.right_rev_pin));
        check_field("duty_out", 8'(res_ch.duty_out), 8'(want.duty_out));
        check_field("heading", 8'(res_ch.heading), 8'(want.heading));
        check_field("busy_res", 8'(res_ch.busy_res), 8'(want.busy_res));
        check_field("accepted", 8'(res_ch.accepted), 8'(want.accepted));
        status_checked++;
      end
    end
  end

  // all stimulus tasks start and end at a falling edge
  task automatic send_item(input logic [2:0] c, input logic [8:0] v);
    hbd_pkg::res_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= c;
    cmd_ch.value <= v;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    step_sequencer(c, v, r);
    pending_status.push_back(r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(hbd_pkg::CMD_TICK, 9'($urandom));
  endtask

  task automatic wait_for_status();
    cmd_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    regs[idx] = (idx < hbd_pkg::REG_SETTLE_TICKS) ? (data & 16'h007F) : data;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(input int lo, input int hi, input int turn, input int dflt,
                          input int settle, input int ramp, input int shrt, input int lng);
    write_reg(hbd_pkg::REG_LOWEST_DUTY, 16'(lo));
    write_reg(hbd_pkg::REG_HIGHEST_DUTY, 16'(hi));
    write_reg(hbd_pkg::REG_TURN_DUTY, 16'(turn));
    write_reg(hbd_pkg::REG_DEFAULT_DUTY, 16'(dflt));
    write_reg(hbd_pkg::REG_SETTLE_TICKS, 16'(settle));
    write_reg(hbd_pkg::REG_RAMP_TICKS, 16'(ramp));
    write_reg(hbd_pkg::REG_SHORT_TICKS, 16'(shrt));
    write_reg(hbd_pkg::REG_LONG_TICKS, 16'(lng));
    settings_loaded++;
  endtask

  function automatic int pick_duty();
    case ($urandom_range(4))
      0:       return 0;
      1:       return 100;
      default: return $urandom_range(100);
    endcase
  endfunction

  function automatic logic [8:0] pick_value(input logic [2:0] c);
    if ((c == hbd_pkg::CMD_LEFT || c == hbd_pkg::CMD_RIGHT) && $urandom_range(1))
      return 9'($urandom_range(93, 85));
    if (c == hbd_pkg::CMD_SPEED && $urandom_range(1)) return 9'($urandom_range(100));
    return 9'($urandom);
  endfunction

  task automatic random_settings();
    int lo;
    int hi;
    lo = ($urandom_range(3) == 0) ? pick_duty() : $urandom_range(30);
    hi = ($urandom_range(3) == 0) ? pick_duty() : $urandom_range(100, 60);
    set_regs(lo, hi, pick_duty(), pick_duty(), $urandom_range(4), $urandom_range(2, 1),
             $urandom_range(6), $urandom_range(8));
  endtask

  // mostly a command followed by a run of ticks, the rest single noise items
  task automatic run_traffic(input int n);
    int count;
    int k;
    logic [2:0] c;
    count = 0;
    while (count < n) begin
      if ($urandom_range(9) < 7) begin
        c = 3'($urandom_range(5));
        send_item(c, pick_value(c));
        k = $urandom_range(20);
        send_ticks(k);
        count += 1 + k;
      end else begin
        c = 3'($urandom_range(7));
        send_item(c, pick_value(c));
        count++;
      end
    end
  endtask

  task automatic test_reset_state();
    send_item(hbd_pkg::CMD_IGNORE, 9'h1FF);
    send_item(hbd_pkg::CMD_SPEED, 9'd0);
    send_item(hbd_pkg::CMD_SPEED, 9'h1FF);
    wait_for_status();
  endtask

  task automatic test_directed_moves();
    set_regs(20, 100, 50, 50, 1, 1, 0, 1);
    send_item(hbd_pkg::CMD_SPEED, 9'd22);
    send_item(hbd_pkg::CMD_FWD, 9'd0);
    send_ticks(4);
    send_item(hbd_pkg::CMD_FWD, 9'd0);
    send_item(hbd_pkg::CMD_STOP, 9'd0);
    send_item(hbd_pkg::CMD_LEFT, 9'd120);   // rejected while the stop settles
    send_ticks(1);
    send_item(hbd_pkg::CMD_LEFT, 9'd88);
    send_ticks(2);
    send_item(hbd_pkg::CMD_RIGHT, hbd_pkg::LONG_TURN_DEG);
    send_ticks(3);
    send_item(hbd_pkg::CMD_BWD, 9'd0);
    send_ticks(4);
    wait_for_status();
  endtask

  task automatic test_register_limits();
    // crossed limits: the ceiling wins; all waits zero but the ramp step
    set_regs(80, 30, 50, 0, 0, 1, 0, 0);
    send_item(hbd_pkg::CMD_SPEED, 9'd50);
    send_item(hbd_pkg::CMD_LEFT, 9'd100);
    send_item(hbd_pkg::CMD_STOP, 9'd0);
    wait_for_status();
    // ramp goal under the floor leaves the duty alone
    set_regs(0, 100, 100, 50, 0, 1, 0, 0);
    send_item(hbd_pkg::CMD_SPEED, 9'd10);
    wait_for_status();
    write_reg(hbd_pkg::REG_LOWEST_DUTY, 16'd40);
    send_item(hbd_pkg::CMD_FWD, 9'd0);
    wait_for_status();
    // longest waits, then a shortened settle ends the stop on the next tick
    set_regs(0, 100, 0, 100, 65535, 65535, 65535, 65535);
    send_item(hbd_pkg::CMD_STOP, 9'd0);
    send_ticks(2);
    wait_for_status();
    write_reg(hbd_pkg::REG_SETTLE_TICKS, 16'd0);
    send_ticks(1);
    wait_for_status();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    repeat (3) begin
      wait_for_status();
      random_settings();
      run_traffic(150);
    end
    wait_for_status();
  endtask

  task automatic test_input_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 20;
    random_settings();
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    run_traffic(60);
    wait_for_status();
  endtask

  initial begin
    int guard;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd   = hbd_pkg::CMD_IGNORE;
    cmd_ch.value = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = hbd_pkg::REG_LOWEST_DUTY;
    cfg_ch.data  = '0;
    mismatches = 0;
    items_sent = 0;
    status_checked = 0;
    settings_loaded = 0;
    hold_left = 0;
    send_gap_pct = 35;
    recv_gap_pct = 62;
    reset_sequencer_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_directed_moves();
    test_register_limits();
    test_random_traffic(35, 62);
    test_random_traffic(62, 35);
    test_input_backpressure();
    test_random_traffic(0, 0);

    cmd_ch.valid <= 1'b0;
    guard = 0;
    while (pending_status.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_status.size() != 0)
      report_mismatch($sformatf("%0d status transfers never arrived", pending_status.size()));

    $display("Sent %0d commands and ticks over %0d register settings, checked %0d transfers.",
             items_sent, settings_loaded, status_checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/hbd_pkg.sv
rtl/hbd_intf.sv
rtl/hbd_cfg_regs.sv
rtl/hbd_seq_core.sv
rtl/h_bridge_drive_sequencer.sv
dv/h_bridge_drive_sequencer_tb.sv
